FILE: rtl/qrv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrv_pkg
// Widths, product routing tables and the flush helper shared by the
// quaternion vector rotation datapath.
// ----------------------------------------------------------------------------
package qrv_pkg;

  // Field and register widths
  localparam int Q_W   = 32;          // quaternion / vector / result fields
  localparam int CFG_W = 16;          // flush threshold register
  localparam int FRAC  = 30;          // Q2.30 fraction bits dropped per product

  // Datapath widths
  localparam int M1_W  = 2 * Q_W - FRAC;   // first-pass product after shift
  localparam int P_W   = M1_W + 2;         // first-pass sum of three products
  localparam int B_W   = Q_W + 1;          // conjugate component (holds -(-2^31))
  localparam int HI_W  = P_W - FRAC;       // upper slice of a first-pass value
  localparam int LO_W  = B_W;              // shifted lower-slice product
  localparam int T_W   = HI_W + B_W + 1;   // one second-pass product term
  localparam int R_W   = T_W + 2;          // second-pass sum of four terms

  localparam int N_TERM = 12;

  // First pass p = q * (0,v): three products per component, p0..p3 in order.
  // Vector index 0..2 stands for x..z; quaternion index 0..3 for w..z.
  localparam logic [1:0] P1_V [N_TERM] = '{
    2'd0, 2'd1, 2'd2,
    2'd0, 2'd2, 2'd1,
    2'd1, 2'd2, 2'd0,
    2'd2, 2'd1, 2'd0
  };
  localparam logic [1:0] P1_Q [N_TERM] = '{
    2'd1, 2'd2, 2'd3,
    2'd0, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd3,
    2'd0, 2'd1, 2'd2
  };
  localparam logic P1_NEG [N_TERM] = '{
    1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0,
    1'b0, 1'b0, 1'b1
  };

  // Second pass r = p * conj(q): four terms per vector component r1..r3.
  // The scalar part is never observed, so it is not built.
  localparam logic [1:0] P2_A [N_TERM] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3
  };
  localparam logic [1:0] P2_B [N_TERM] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd3, 2'd0, 2'd1,
    2'd3, 2'd2, 2'd1, 2'd0
  };
  localparam logic P2_NEG [N_TERM] = '{
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b0
  };

  // Zero a component whose magnitude is at or below the threshold
  function automatic logic signed [R_W-1:0] flush_cmp(
    input logic signed [R_W-1:0] c,
    input logic [CFG_W-1:0]      thr
  );
    logic signed [R_W-1:0] t;
    t = $signed({{(R_W - CFG_W){1'b0}}, thr});
    if ((c <= t) && (c >= -t)) begin
      return '0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/quaternion_rotate_vector_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_unit
// The result strobe comes from a valid chain that runs alongside the data
// and is registered in step with the result fields.
// Throughput: one transaction per cycle; six fully pipelined multiply/add
// stages, busy is low whenever the block is out of reset.
// Reset: synchronous, active low; clears the valid chain and sets the flush
// threshold to 1. The receiver cannot stall, so results are never held.
// Rotates a Q16.16 vector by a Q2.30 quaternion: r = q * (0,v) * conj(q),
// flushing small components after each product and saturating to 32 bits.
// ----------------------------------------------------------------------------
module quaternion_rotate_vector_unit (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // input transaction
  input  wire                                    start,
  output logic                                   busy,
  input  wire logic signed [qrv_pkg::Q_W-1:0]    in_quat_w,
  input  wire logic signed [qrv_pkg::Q_W-1:0]    in_quat_x,
  input  wire logic signed [qrv_pkg::Q_W-1:0]    in_quat_y,
  input  wire logic signed [qrv_pkg::Q_W-1:0]    in_quat_z,
  input  wire logic signed [qrv_pkg::Q_W-1:0]    in_vec_x,
  input  wire logic signed [qrv_pkg::Q_W-1:0]    in_vec_y,
  input  wire logic signed [qrv_pkg::Q_W-1:0]    in_vec_z,
  // result transaction
  output logic                                   out_valid,
  output logic signed [qrv_pkg::Q_W-1:0]         out_rot_x,
  output logic signed [qrv_pkg::Q_W-1:0]         out_rot_y,
  output logic signed [qrv_pkg::Q_W-1:0]         out_rot_z,
  output logic                                   out_overflow,
  // configuration
  input  wire                                    cfg_wr_en,
  input  wire logic [qrv_pkg::CFG_W-1:0]         cfg_wr_data
);
  import qrv_pkg::*;

  localparam logic [CFG_W-1:0] THR_RESET = CFG_W'(1);
  localparam int               N_VLD     = 5;

  logic                    busy_r;
  logic                    accept;
  logic [CFG_W-1:0]        thr_r;
  logic [N_VLD-1:0]        vld_r;

  logic signed [Q_W-1:0]   vin [3];
  logic signed [Q_W-1:0]   qin [4];
  logic signed [2*Q_W-1:0] m1_prod [N_TERM];
  logic signed [M1_W-1:0]  m1_nxt [N_TERM];
  logic signed [M1_W-1:0]  m1_r [N_TERM];
  logic signed [Q_W-1:0]   qd_r [4];

  logic signed [R_W-1:0]   p_acc [4];
  logic signed [R_W-1:0]   p_te [N_TERM];
  logic signed [P_W-1:0]   p_nxt [4];
  logic signed [P_W-1:0]   p_r [4];
  logic signed [B_W-1:0]   qc_nxt [4];
  logic signed [B_W-1:0]   qc_r [4];

  logic signed [T_W-1:0]   term [N_TERM];
  logic signed [R_W-1:0]   r_te [N_TERM];
  logic signed [R_W-1:0]   r_acc [3];
  logic signed [R_W-1:0]   r_nxt [3];
  logic signed [R_W-1:0]   r_r [3];

  logic [2:0]              sat_hit;
  logic signed [Q_W-1:0]   rot_nxt [3];
  logic signed [Q_W-1:0]   rot_r [3];
  logic                    ovf_r;
  logic                    out_valid_r;

  // Handshake: only held off while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Flush threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[N_VLD-2:0], accept};
      out_valid_r <= vld_r[N_VLD-1];
    end
  end

  // Stage 1: twelve vector x quaternion products, floored to Q16.16
  always_comb begin
    vin[0] = in_vec_x;
    vin[1] = in_vec_y;
    vin[2] = in_vec_z;
    qin[0] = in_quat_w;
    qin[1] = in_quat_x;
    qin[2] = in_quat_y;
    qin[3] = in_quat_z;
    for (int k = 0; k < N_TERM; k++) begin
      m1_prod[k] = vin[P1_V[k]] * qin[P1_Q[k]];
      m1_nxt[k]  = M1_W'(m1_prod[k] >>> FRAC);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_TERM; k++) begin
      m1_r[k] <= m1_nxt[k];
    end
    for (int i = 0; i < 4; i++) begin
      qd_r[i] <= qin[i];
    end
  end

  // Stage 2: sum into p = q * (0,v), flush, and form conj(q)
  always_comb begin
    for (int k = 0; k < N_TERM; k++) begin
      p_te[k] = R_W'(m1_r[k]);
    end
    for (int j = 0; j < 4; j++) begin
      p_acc[j] = '0;
      for (int t = 0; t < 3; t++) begin
        if (P1_NEG[3*j+t]) begin
          p_acc[j] = p_acc[j] - p_te[3*j+t];
        end else begin
          p_acc[j] = p_acc[j] + p_te[3*j+t];
        end
      end
      p_nxt[j] = P_W'(flush_cmp(p_acc[j], thr_r));
    end
    qc_nxt[0] = $signed({qd_r[0][Q_W-1], qd_r[0]});
    for (int i = 1; i < 4; i++) begin
      qc_nxt[i] = -$signed({qd_r[i][Q_W-1], qd_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      p_r[j]  <= p_nxt[j];
      qc_r[j] <= qc_nxt[j];
    end
  end

  // Stages 3 and 4: twelve split products for r = p * conj(q)
  for (genvar k = 0; k < N_TERM; k++) begin : g_term
    qrv_term_mul u_term_mul (
      .clk  (clk),
      .a    (p_r[P2_A[k]]),
      .b    (qc_r[P2_B[k]]),
      .term (term[k])
    );
  end

  // Stage 5: four-term sums for the vector part, flushed
  always_comb begin
    for (int k = 0; k < N_TERM; k++) begin
      r_te[k] = R_W'(term[k]);
    end
    for (int j = 0; j < 3; j++) begin
      r_acc[j] = '0;
      for (int t = 0; t < 4; t++) begin
        if (P2_NEG[4*j+t]) begin
          r_acc[j] = r_acc[j] - r_te[4*j+t];
        end else begin
          r_acc[j] = r_acc[j] + r_te[4*j+t];
        end
      end
      r_nxt[j] = flush_cmp(r_acc[j], thr_r);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      r_r[j] <= r_nxt[j];
    end
  end

  // Stage 6: saturate to 32 bits; fits when all bits above the sign agree
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sat_hit[j] = !((&r_r[j][R_W-1:Q_W-1]) || !(|r_r[j][R_W-1:Q_W-1]));
      if (sat_hit[j]) begin
        rot_nxt[j] = r_r[j][R_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end else begin
        rot_nxt[j] = r_r[j][Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      rot_r[j] <= rot_nxt[j];
    end
    ovf_r <= |sat_hit;
  end

  assign out_valid    = out_valid_r;
  assign out_rot_x    = rot_r[0];
  assign out_rot_y    = rot_r[1];
  assign out_rot_z    = rot_r[2];
  assign out_overflow = ovf_r;

  // Each result strobe comes from an accepted transaction
  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 6))
    else $error("result strobe without an accepted transaction");

  // Every accepted transaction produces a result
  a_in_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_valid)
    else $error("accepted transaction lost in the pipeline");

  // Overflow implies at least one component sits at a rail
  a_ovf_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |->
      (out_rot_x == {1'b0, {(Q_W-1){1'b1}}} || out_rot_x == {1'b1, {(Q_W-1){1'b0}}} ||
       out_rot_y == {1'b0, {(Q_W-1){1'b1}}} || out_rot_y == {1'b1, {(Q_W-1){1'b0}}} ||
       out_rot_z == {1'b0, {(Q_W-1){1'b1}}} || out_rot_z == {1'b1, {(Q_W-1){1'b0}}}))
    else $error("overflow flagged with no saturated component");

  // Without saturation no result component lies inside the flush band
  a_flush_band: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_overflow) |->
      ((out_rot_x == '0 || out_rot_x > $signed({1'b0, thr_r}) ||
        out_rot_x < -$signed({1'b0, thr_r})) &&
       (out_rot_y == '0 || out_rot_y > $signed({1'b0, thr_r}) ||
        out_rot_y < -$signed({1'b0, thr_r})) &&
       (out_rot_z == '0 || out_rot_z > $signed({1'b0, thr_r}) ||
        out_rot_z < -$signed({1'b0, thr_r}))))
    else $error("unflushed small component in result");

endmodule
`default_nettype wire

FILE: rtl/qrv_term_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrv_term_mul
// Two-stage product floor(a * b / 2^30) for a wide first-pass value and a
// conjugate component. The wide operand is split at bit 30 so that each
// multiplier stays near 32x32; the partial products are registered, then summed in the next cycle.
// ----------------------------------------------------------------------------
module qrv_term_mul (
  input  wire                              clk,
  input  wire logic signed [qrv_pkg::P_W-1:0] a,
  input  wire logic signed [qrv_pkg::B_W-1:0] b,
  output logic signed [qrv_pkg::T_W-1:0]      term
);
  import qrv_pkg::*;

  logic signed [HI_W+B_W-1:0] hi_nxt, hi_r;
  logic signed [FRAC+1+B_W-1:0] lo_prod;
  logic signed [LO_W-1:0]     lo_nxt, lo_r;
  logic signed [T_W-1:0]      term_r;

  // Partial products: upper slice exact, lower slice floored by 2^30
  always_comb begin
    hi_nxt  = $signed(a[P_W-1:FRAC]) * b;
    lo_prod = $signed({1'b0, a[FRAC-1:0]}) * b;
    lo_nxt  = LO_W'(lo_prod >>> FRAC);
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  // Recombine the two partial products
  always_ff @(posedge clk) begin
    term_r <= T_W'(hi_r) + T_W'(lo_r);
  end

  assign term = term_r;

endmodule
`default_nettype wire

FILE: sim/quaternion_rotate_vector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_unit_tb
// Self-checking bench for the quaternion vector rotation unit. A table of
// directed transactions covers the field extremes, identity and half-turn
// rotations, saturation and flushing at several thresholds. Random phases
// follow, each under its own flush threshold, with bursty start traffic.
// Every accepted transaction is predicted from the input ports, or takes
// its hand-written expectation, and is compared field by field with the next result strobe.
// ----------------------------------------------------------------------------
module quaternion_rotate_vector_unit_tb;
  import qrv_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [Q_W-1:0] qw;
    logic signed [Q_W-1:0] qx;
    logic signed [Q_W-1:0] qy;
    logic signed [Q_W-1:0] qz;
    logic signed [Q_W-1:0] vx;
    logic signed [Q_W-1:0] vy;
    logic signed [Q_W-1:0] vz;
  } rot_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
    logic                  ovf;
  } rot_vec_t;

  typedef struct {
    logic [CFG_W-1:0] thr;
    rot_item_t        item;
    logic             has_exp;
    rot_vec_t         exp_res;
  } stim_row_t;

  localparam logic signed [Q_W-1:0] ONE_Q = 32'sh4000_0000;  // 1.0 in Q2.30
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 230;
  localparam int SETTLE_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [Q_W-1:0] in_quat_w = '0;
  logic signed [Q_W-1:0] in_quat_x = '0;
  logic signed [Q_W-1:0] in_quat_y = '0;
  logic signed [Q_W-1:0] in_quat_z = '0;
  logic signed [Q_W-1:0] in_vec_x = '0;
  logic signed [Q_W-1:0] in_vec_y = '0;
  logic signed [Q_W-1:0] in_vec_z = '0;
  logic out_valid;
  logic signed [Q_W-1:0] out_rot_x;
  logic signed [Q_W-1:0] out_rot_y;
  logic signed [Q_W-1:0] out_rot_z;
  logic out_overflow;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  // Hand-written expectation travels along with the transaction
  logic     use_listed = 1'b0;
  rot_vec_t listed_res = '0;

  rot_vec_t         expected_rotations[$];
  stim_row_t        directed_rows[$];
  logic [CFG_W-1:0] thr_model = 16'd1;
  int               mismatch_count = 0;

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  quaternion_rotate_vector_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_quat_w    (in_quat_w),
    .in_quat_x    (in_quat_x),
    .in_quat_y    (in_quat_y),
    .in_quat_z    (in_quat_z),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .out_valid    (out_valid),
    .out_rot_x    (out_rot_x),
    .out_rot_y    (out_rot_y),
    .out_rot_z    (out_rot_z),
    .out_overflow (out_overflow),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // Exact product of a Q16.16 and a Q2.30 value, floored back to Q16.16
  function automatic wide_t qmul(input wide_t a, input wide_t b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic wide_t flush_small(input wide_t c, input logic [CFG_W-1:0] thr);
    wide_t mag;
    wide_t lim;
    mag = (c < 0) ? -c : c;
    lim = '0;
    lim[CFG_W-1:0] = thr;
    return (mag <= lim) ? '0 : c;
  endfunction

  // r = q * (0,v) * conj(q), flushed after each product, saturated at the end
  function automatic rot_vec_t rotate_predict(input rot_item_t it,
                                              input logic [CFG_W-1:0] thr);
    wide_t w, x, y, z, vx, vy, vz, cx, cy, cz;
    wide_t p0, p1, p2, p3;
    wide_t r[3];
    wide_t hi, lo;
    logic signed [Q_W-1:0] o[3];
    rot_vec_t res;
    w  = it.qw;
    x  = it.qx;
    y  = it.qy;
    z  = it.qz;
    vx = it.vx;
    vy = it.vy;
    vz = it.vz;
    cx = -x;
    cy = -y;
    cz = -z;
    p0 = flush_small(-qmul(vx, x) - qmul(vy, y) - qmul(vz, z), thr);
    p1 = flush_small(qmul(vx, w) + qmul(vz, y) - qmul(vy, z), thr);
    p2 = flush_small(qmul(vy, w) - qmul(vz, x) + qmul(vx, z), thr);
    p3 = flush_small(qmul(vz, w) + qmul(vy, x) - qmul(vx, y), thr);
    r[0] = flush_small(qmul(p0, cx) + qmul(p1, w) + qmul(p2, cz) - qmul(p3, cy), thr);
    r[1] = flush_small(qmul(p0, cy) - qmul(p1, cz) + qmul(p2, w) + qmul(p3, cx), thr);
    r[2] = flush_small(qmul(p0, cz) + qmul(p1, cy) - qmul(p2, cx) + qmul(p3, w), thr);
    hi = 2147483647;
    lo = -hi - 1;
    res.ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (r[i] > hi) begin
        o[i] = hi[Q_W-1:0];
        res.ovf = 1'b1;
      end else if (r[i] < lo) begin
        o[i] = lo[Q_W-1:0];
        res.ovf = 1'b1;
      end else begin
        o[i] = r[i][Q_W-1:0];
      end
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  function automatic void add_row(
    input logic [CFG_W-1:0] thr,
    input logic signed [Q_W-1:0] qw, qx, qy, qz, vx, vy, vz,
    input logic has_exp,
    input logic signed [Q_W-1:0] ex, ey, ez,
    input logic eo
  );
    stim_row_t row;
    row.thr     = thr;
    row.item    = {qw, qx, qy, qz, vx, vy, vz};
    row.has_exp = has_exp;
    row.exp_res = {ex, ey, ez, eo};
    directed_rows.push_back(row);
  endfunction

  // Random value, arithmetic-shifted by a random amount to spread magnitudes
  function automatic logic signed [Q_W-1:0] rand_scaled(input int lo_sh, input int hi_sh);
    logic signed [Q_W-1:0] raw;
    raw = $signed($urandom);
    return raw >>> $urandom_range(lo_sh, hi_sh);
  endfunction

  // Mostly near-unit quaternions with mid-range vectors, some raw noise and
  // some tiny values that sit around the flush threshold
  function automatic rot_item_t random_item();
    rot_item_t it;
    int mode;
    int q_lo, q_hi, v_lo, v_hi;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      q_lo = 0; q_hi = 0; v_lo = 0; v_hi = 0;
    end else if (mode < 8) begin
      q_lo = 1; q_hi = 2; v_lo = 0; v_hi = 24;
    end else begin
      q_lo = 0; q_hi = 31; v_lo = 14; v_hi = 31;
    end
    it.qw = rand_scaled(q_lo, q_hi);
    it.qx = rand_scaled(q_lo, q_hi);
    it.qy = rand_scaled(q_lo, q_hi);
    it.qz = rand_scaled(q_lo, q_hi);
    it.vx = rand_scaled(v_lo, v_hi);
    it.vy = rand_scaled(v_lo, v_hi);
    it.vz = rand_scaled(v_lo, v_hi);
    return it;
  endfunction

  task automatic report_field(input string name, input logic signed [Q_W-1:0] want,
                              input logic signed [Q_W-1:0] got);
    $display("%0t: %s mismatch, expected %0d (0x%08h) actual %0d (0x%08h)",
             $time, name, want, want, got, got);
    mismatch_count++;
  endtask

  // Present one transaction and hold it until the block takes it
  task automatic drive_item(input rot_item_t it, input logic listed, input rot_vec_t res);
    start      <= 1'b1;
    in_quat_w  <= it.qw;
    in_quat_x  <= it.qx;
    in_quat_y  <= it.qy;
    in_quat_z  <= it.qz;
    in_vec_x   <= it.vx;
    in_vec_y   <= it.vy;
    in_vec_z   <= it.vz;
    use_listed <= listed;
    listed_res <= res;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain the pipe completely, then write the threshold
  task automatic load_threshold(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Scoreboard: track the threshold, check strobes, predict accepted inputs
  always @(posedge clk) begin
    rot_vec_t got;
    rot_vec_t want;
    if (!rst_n) begin
      thr_model = 16'd1;
    end else begin
      if (cfg_wr_en) begin
        thr_model = cfg_wr_data;
      end
      if (out_valid) begin
        got = {out_rot_x, out_rot_y, out_rot_z, out_overflow};
        if (expected_rotations.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d ovf=%0b",
                   $time, got.x, got.y, got.z, got.ovf);
          mismatch_count++;
        end else begin
          want = expected_rotations.pop_front();
          if (got.x !== want.x) report_field("rot_x", want.x, got.x);
          if (got.y !== want.y) report_field("rot_y", want.y, got.y);
          if (got.z !== want.z) report_field("rot_z", want.z, got.z);
          if (got.ovf !== want.ovf) begin
            report_field("overflow", Q_W'(want.ovf), Q_W'(got.ovf));
          end
        end
      end
      if (start && !busy) begin
        expected_rotations.push_back(use_listed ? listed_res :
          rotate_predict({in_quat_w, in_quat_x, in_quat_y, in_quat_z,
                          in_vec_x, in_vec_y, in_vec_z}, thr_model));
      end
    end
  end

  // Stimulus
  initial begin
    logic [CFG_W-1:0] thr_now;
    int burst_left;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    thr_now = 16'd1;

    // Threshold left at its reset value
    add_row(1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(1, ONE_Q, 0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
            1, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 0);
    add_row(1, ONE_Q, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0002,
            1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0002, 0);
    // +/-1 LSB flushed away
    add_row(1, ONE_Q, 0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
            1, 0, 0, 32'h0000_0002, 0);
    // w = -2.0 scales by four: saturates both ways
    add_row(1, 32'h8000_0000, 0, 0, 0, 32'h4000_0000, 32'hC000_0000, 32'h0001_0000,
            1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0004_0000, 1);
    // Half turn about z: negating the most negative x saturates
    add_row(1, 0, 0, 0, ONE_Q, 32'h8000_0000, 32'h0002_0000, 32'h0003_0000,
            1, 32'h7FFF_FFFF, 32'hFFFE_0000, 32'h0003_0000, 1);
    // w = 0.5, non-unit: vector shrinks to a quarter
    add_row(1, 32'h2000_0000, 0, 0, 0, 32'h0004_0000, 32'hFFFC_0000, 0,
            1, 32'h0001_0000, 32'hFFFF_0000, 0, 0);
    add_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    add_row(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(1, 32'h2D41_3CCD, 0, 0, 32'h2D41_3CCD, 32'h0001_0000, 0, 0,
            0, 0, 0, 0, 0);
    add_row(1, 32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0, 32'h0005_0000, 32'h0003_0000,
            32'hFFFE_0000, 0, 0, 0, 0, 0);
    add_row(1, 0, ONE_Q, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
            0, 0, 0, 0, 0);
    add_row(1, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
            32'h0001_0000, 0, 0, 0, 0, 0, 0, 0);
    // Threshold zero: nothing but exact zeros is flushed
    add_row(0, ONE_Q, 0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0,
            1, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
    add_row(0, 32'h0000_0001, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
            0, 0, 0, 0, 0);
    add_row(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, 0, 0, 0, 0);
    // Largest threshold: anything under 1.0 disappears
    add_row(16'hFFFF, ONE_Q, 0, 0, 0, 32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0001,
            1, 0, 32'h0001_0000, 0, 0);
    add_row(16'hFFFF, ONE_Q, 0, 0, 0, 32'h0001_0001, 32'hFFFE_FFFF, 32'h7FFF_FFFF,
            1, 32'h0001_0001, 32'hFFFE_FFFF, 32'h7FFF_FFFF, 0);
    add_row(16'hFFFF, 32'h6000_0000, 32'h1000_0000, 32'hF000_0000, 32'h3000_0000,
            32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 0, 0, 0, 0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].thr != thr_now) begin
        thr_now = directed_rows[i].thr;
        load_threshold(thr_now);
      end
      drive_item(directed_rows[i].item, directed_rows[i].has_exp, directed_rows[i].exp_res);
    end

    // Random phases, each starting from an empty pipe
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       thr_now = '0;
        1:       thr_now = '1;
        2:       thr_now = CFG_W'($urandom_range(2, 4096));
        3:       thr_now = 16'd1;
        default: thr_now = CFG_W'($urandom_range(2, 65534));
      endcase
      load_threshold(thr_now);
      burst_left = 0;
      repeat (PHASE_ITEMS) begin
        if (burst_left == 0) begin
          pause_cycles($urandom_range(0, 6));
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) :
                                                     $urandom_range(1, 16);
        end
        drive_item(random_item(), 1'b0, '0);
        burst_left--;
      end
    end

    start <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rotations.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
